FILE: design/kid_pkg.sv
`timescale 1ns / 1ps
// kid_pkg: shared constants and codes of the key-to-ID dictionary table
// no dependencies

package kid_pkg;

    localparam int DEPTH = 256;
    localparam int KEY_W = 64;
    localparam int ID_W  = $clog2(DEPTH);
    localparam int CNT_W = ID_W + 1;

    localparam logic [3:0] CMD_GET      = 4'd0;
    localparam logic [3:0] CMD_NEXT     = 4'd1;
    localparam logic [3:0] CMD_UNSET    = 4'd2;
    localparam logic [3:0] CMD_RESET    = 4'd3;
    localparam logic [3:0] CMD_FIND     = 4'd4;
    localparam logic [3:0] CMD_INSERT   = 4'd5;
    localparam logic [3:0] CMD_REMOVE   = 4'd6;
    localparam logic [3:0] CMD_UPDATE   = 4'd7;
    localparam logic [3:0] CMD_TRUNCATE = 4'd8;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD_ID  = 3'd1;
    localparam logic [2:0] ST_ABSENT  = 3'd2;
    localparam logic [2:0] ST_PRESENT = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_ACT  = 3'b100
    } t_state;

endpackage

FILE: design/kid_ram.sv
`timescale 1ns / 1ps
// kid_ram: simple dual-port key memory, one write and one registered read per cycle
// no dependencies

module kid_ram #(
    parameter int DW = 64,
    parameter int AW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/key_to_id_dictionary_table.sv
`timescale 1ns / 1ps
// key_to_id_dictionary_table: top level, command sequencer, scan engine and result register
// depends on kid_pkg and kid_ram

// Maps integer keys to dense IDs 0..255.
// Input channel (i_s_*): one word per command; tuser carries the command code,
// tdata the slot ID, the key and the new key. Output channel (o_m_*): one
// result word per command; tuser carries ok and status, tdata the ID, key,
// count, highest ID and free-slot hint.
// One command is worked at a time. The keys sit in a memory with one
// registered read port; searches walk the slots 0..highest ID one read per
// cycle. Find, insert, remove and reset scan once, update up to twice, get
// and unset read one slot, next scans up from the given ID and truncate
// needs no scan. The memory read port sets the scan rate.
// Reset empties the table at once (valid bits are flip-flops); no clearing
// pass is needed. When the receiver stalls the result waits in the output
// register and the next command is taken, but its result waits for the slot.

module key_to_id_dictionary_table (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [143:0] i_s_tdata,  // slot_id[8:0], key[72:9], new_key[136:73], zero pad
    input  logic [3:0]   i_s_tuser,  // cmd[3:0]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [103:0] o_m_tdata,  // found_id[7:0], found_key[71:8], entry_count[80:72],
                                     // top_id[89:81], hint_id[98:90], zero pad
    output logic [3:0]   o_m_tuser   // ok[0], status[3:1]
);
    import kid_pkg::*;

    // input fields
    logic [3:0]        in_cmd;
    logic signed [8:0] in_id;
    logic [KEY_W-1:0]  in_key, in_nk;
    assign in_cmd = i_s_tuser;
    assign in_id  = $signed(i_s_tdata[8:0]);
    assign in_key = i_s_tdata[72:9];
    assign in_nk  = i_s_tdata[136:73];

    t_state r_state, n_state;
    logic [DEPTH-1:0]    r_valid, n_valid;
    logic signed [8:0]   r_top, n_top;
    logic [CNT_W-1:0]    r_hint, n_hint, r_count, n_count;
    logic [3:0]          r_cmd, n_cmd;
    logic signed [8:0]   r_id, n_id;
    logic [KEY_W-1:0]    r_key, n_key, r_nk, n_nk;
    logic                r_bad, n_bad, r_phase, n_phase;
    logic [ID_W-1:0]     r_src, n_src;
    // scan engine
    logic [CNT_W-1:0]    r_ptr, n_ptr;
    logic signed [8:0]   r_lim, n_lim;
    logic                r_keymode, n_keymode;
    logic [KEY_W-1:0]    r_target, n_target;
    logic                r_ev, n_ev, r_ev_last, n_ev_last;
    logic [ID_W-1:0]     r_ev_idx, n_ev_idx;
    logic                r_hit, n_hit;
    logic [ID_W-1:0]     r_hit_idx, n_hit_idx;
    logic [KEY_W-1:0]    r_hit_key, n_hit_key;
    logic                r_first_v, n_first_v, r_second_v, n_second_v;
    logic [ID_W-1:0]     r_first, n_first, r_second, n_second;
    // result register
    logic                r_out_vld, n_out_vld;
    logic [103:0]        r_out_data, n_out_data;
    logic [3:0]          r_out_user, n_out_user;
    // memory
    logic                mem_we;
    logic [ID_W-1:0]     mem_waddr;
    logic [KEY_W-1:0]    mem_wdata, mem_rdata;

    logic s_acc, issue, ev_match, usable, act_go;
    logic [CNT_W-1:0]    top_next;
    logic                res_ok;
    logic [2:0]          res_st;
    logic [ID_W-1:0]     res_id;
    logic [KEY_W-1:0]    res_key;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign issue      = !r_lim[8] && (r_ptr <= {1'b0, r_lim[ID_W-1:0]});
    assign ev_match   = r_valid[r_ev_idx] && (!r_keymode || mem_rdata == r_target);
    assign usable     = !in_id[8] && (in_id <= r_top) && r_valid[in_id[ID_W-1:0]];
    assign act_go     = !r_out_vld || i_m_tready;
    assign top_next   = CNT_W'(r_top + 9'sd1);

    kid_ram #(.DW(KEY_W), .AW(ID_W)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_ptr[ID_W-1:0]),
        .o_rdata (mem_rdata)
    );

    // sequencer, scan and command actions
    always_comb begin
        n_state = r_state;   n_valid = r_valid;   n_top = r_top;
        n_hint = r_hint;     n_count = r_count;   n_cmd = r_cmd;
        n_id = r_id;         n_key = r_key;       n_nk = r_nk;
        n_bad = r_bad;       n_phase = r_phase;   n_src = r_src;
        n_ptr = r_ptr;       n_lim = r_lim;       n_keymode = r_keymode;
        n_target = r_target; n_ev = 1'b0;         n_ev_last = r_ev_last;
        n_ev_idx = r_ev_idx; n_hit = r_hit;       n_hit_idx = r_hit_idx;
        n_hit_key = r_hit_key;
        n_first_v = r_first_v; n_first = r_first;
        n_second_v = r_second_v; n_second = r_second;
        n_out_vld = r_out_vld && !i_m_tready;
        n_out_data = r_out_data; n_out_user = r_out_user;
        mem_we = 1'b0; mem_waddr = '0; mem_wdata = r_nk;
        res_ok = 1'b0; res_st = ST_BAD_ID; res_id = '0; res_key = '0;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_cmd = in_cmd; n_id = in_id; n_key = in_key; n_nk = in_nk;
                    n_bad = 1'b0; n_phase = 1'b0; n_hit = 1'b0;
                    n_first_v = 1'b0; n_second_v = 1'b0;
                    n_ptr = '0; n_lim = r_top; n_keymode = 1'b1; n_target = in_key;
                    n_state = S_SCAN;
                    case (in_cmd)
                        CMD_GET, CMD_UNSET: begin
                            n_keymode = 1'b0;
                            n_ptr = CNT_W'(in_id);
                            n_lim = in_id;
                            if (!usable) n_state = S_ACT;
                        end
                        CMD_NEXT: begin
                            n_keymode = 1'b0;
                            n_ptr = in_id[8] ? '0 : CNT_W'(in_id + 9'sd1);
                            if (!(in_id < r_top)) n_state = S_ACT;
                        end
                        CMD_RESET: begin
                            n_target = in_nk;
                            if (!usable) begin
                                n_bad = 1'b1;
                                n_state = S_ACT;
                            end
                        end
                        CMD_FIND, CMD_INSERT, CMD_REMOVE, CMD_UPDATE: ;
                        default: n_state = S_ACT;
                    endcase
                end
            end
            S_SCAN: begin
                // issue one read a cycle, compare in the cycle after
                if (issue) begin
                    n_ev = 1'b1;
                    n_ev_idx = r_ptr[ID_W-1:0];
                    n_ev_last = (r_ptr == {1'b0, r_lim[ID_W-1:0]});
                    n_ptr = r_ptr + 1'b1;
                end
                if (r_ev) begin
                    if (!r_valid[r_ev_idx]) begin
                        if (!r_first_v) begin
                            n_first_v = 1'b1; n_first = r_ev_idx;
                        end else if (!r_second_v) begin
                            n_second_v = 1'b1; n_second = r_ev_idx;
                        end
                    end
                    if (ev_match) begin
                        n_hit = 1'b1; n_hit_idx = r_ev_idx; n_hit_key = mem_rdata;
                        n_ev = 1'b0; n_state = S_ACT;
                    end else if (r_ev_last) begin
                        n_ev = 1'b0; n_state = S_ACT;
                    end
                end else if (!issue) begin
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                if (r_cmd == CMD_UPDATE && !r_phase && r_hit) begin
                    // source found: now search the destination key
                    n_phase = 1'b1; n_src = r_hit_idx; n_hit = 1'b0;
                    n_ptr = '0; n_lim = r_top; n_target = r_nk;
                    n_state = S_SCAN;
                end else if (act_go) begin
                    case (r_cmd)
                        CMD_GET, CMD_NEXT, CMD_UNSET: begin
                            if (r_hit) begin
                                res_ok = 1'b1; res_st = ST_OK;
                                res_id = r_hit_idx; res_key = r_hit_key;
                                if (r_cmd == CMD_UNSET) begin
                                    n_valid[r_hit_idx] = 1'b0;
                                    n_count = r_count - 1'b1;
                                    if ({1'b0, r_hit_idx} < r_hint) n_hint = {1'b0, r_hit_idx};
                                end
                            end
                        end
                        CMD_RESET: begin
                            if (r_bad) res_st = ST_BAD_ID;
                            else if (r_hit) res_st = ST_PRESENT;
                            else begin
                                mem_we = 1'b1; mem_waddr = r_id[ID_W-1:0];
                                res_ok = 1'b1; res_st = ST_OK;
                                res_id = r_id[ID_W-1:0]; res_key = r_nk;
                            end
                        end
                        CMD_FIND, CMD_REMOVE: begin
                            if (!r_hit) res_st = ST_ABSENT;
                            else begin
                                res_ok = 1'b1; res_st = ST_OK;
                                res_id = r_hit_idx; res_key = r_key;
                                if (r_cmd == CMD_REMOVE) begin
                                    n_valid[r_hit_idx] = 1'b0;
                                    n_count = r_count - 1'b1;
                                    if ({1'b0, r_hit_idx} < r_hint) n_hint = {1'b0, r_hit_idx};
                                end
                            end
                        end
                        CMD_INSERT: begin
                            if (r_hit) begin
                                res_st = ST_PRESENT; res_id = r_hit_idx; res_key = r_key;
                            end else if (!r_first_v && r_top == 9'(DEPTH - 1)) begin
                                res_st = ST_FULL;
                            end else begin
                                res_ok = 1'b1; res_st = ST_OK; res_key = r_key;
                                mem_we = 1'b1; mem_wdata = r_key;
                                if (r_first_v) begin
                                    res_id = r_first;
                                    n_hint = r_second_v ? {1'b0, r_second} : top_next;
                                end else begin
                                    res_id = top_next[ID_W-1:0];
                                    n_top = r_top + 9'sd1;
                                    n_hint = top_next + 1'b1;
                                end
                                mem_waddr = res_id;
                                n_valid[res_id] = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_UPDATE: begin
                            if (!r_phase) res_st = ST_ABSENT;
                            else if (r_hit) res_st = ST_PRESENT;
                            else begin
                                mem_we = 1'b1; mem_waddr = r_src;
                                res_ok = 1'b1; res_st = ST_OK;
                                res_id = r_src; res_key = r_nk;
                            end
                        end
                        CMD_TRUNCATE: begin
                            n_valid = '0; n_top = -9'sd1; n_hint = '0; n_count = '0;
                            res_ok = 1'b1; res_st = ST_OK;
                        end
                        default: ;
                    endcase
                    n_out_vld = 1'b1;
                    n_out_user = {res_st, res_ok};
                    n_out_data = {5'd0, n_hint, n_top, n_count, res_key, res_id};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_valid <= '0; r_top <= -9'sd1;
            r_hint <= '0; r_count <= '0; r_ev <= 1'b0; r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state; r_valid <= n_valid; r_top <= n_top;
            r_hint <= n_hint; r_count <= n_count; r_ev <= n_ev; r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd; r_id <= n_id; r_key <= n_key; r_nk <= n_nk;
        r_bad <= n_bad; r_phase <= n_phase; r_src <= n_src;
        r_ptr <= n_ptr; r_lim <= n_lim; r_keymode <= n_keymode; r_target <= n_target;
        r_ev_last <= n_ev_last; r_ev_idx <= n_ev_idx;
        r_hit <= n_hit; r_hit_idx <= n_hit_idx; r_hit_key <= n_hit_key;
        r_first_v <= n_first_v; r_first <= n_first;
        r_second_v <= n_second_v; r_second <= n_second;
        r_out_data <= n_out_data; r_out_user <= n_out_user;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH)) else $error("key count out of range");
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> r_state != S_IDLE) else $error("accepted word not worked");
    a_compare_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev |-> $past(r_state == S_SCAN)) else $error("compare outside scan");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for the key-to-ID dictionary table
// depends on kid_pkg and key_to_id_dictionary_table

module testbench;
    import kid_pkg::*;

    // one expected result word
    typedef struct packed {
        logic        ok;
        logic [2:0]  status;
        logic [7:0]  found_id;
        logic [63:0] found_key;
        logic [8:0]  entry_count;
        logic [8:0]  top_id;
        logic [8:0]  hint_id;
    } t_answer;

    int unsigned n_errors = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        n_errors++;
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    // scoreboard: mirror of the table and queue of expected answers
    class dict_scoreboard;
        bit          used[DEPTH];
        logic [63:0] keys[DEPTH];
        int          top;
        int          hint;
        int          count;
        t_answer     pending[$];

        function new();
            wipe();
        endfunction

        function void wipe();
            foreach (used[i]) used[i] = 0;
            top = -1;
            hint = 0;
            count = 0;
        endfunction

        function int locate(logic [63:0] k);
            for (int i = 0; i <= top; i++)
                if (used[i] && keys[i] == k) return i;
            return -1;
        endfunction

        function bit usable(int id);
            return id >= 0 && id <= top && used[id];
        endfunction

        function void release_slot(int id);
            used[id] = 0;
            if (id < hint) hint = id;
            count--;
        endfunction

        // compute the answer to one accepted command word
        function void note_command(logic [3:0] cmd, logic [8:0] raw_id,
                                   logic [63:0] k, logic [63:0] nk);
            t_answer a;
            int id, hit, first, second;
            id = $signed(raw_id);
            a = '0;
            a.status = ST_BAD_ID;
            case (cmd)
                CMD_GET: if (usable(id)) begin
                    a.ok = 1; a.status = ST_OK; a.found_id = 8'(id); a.found_key = keys[id];
                end
                CMD_NEXT: if (id < top) begin
                    for (int i = (id < 0) ? 0 : id + 1; i <= top; i++)
                        if (used[i]) begin
                            a.ok = 1; a.status = ST_OK; a.found_id = 8'(i);
                            a.found_key = keys[i];
                            break;
                        end
                end
                CMD_UNSET: if (usable(id)) begin
                    a.ok = 1; a.status = ST_OK; a.found_id = 8'(id); a.found_key = keys[id];
                    release_slot(id);
                end
                CMD_RESET: begin
                    if (!usable(id)) a.status = ST_BAD_ID;
                    else if (locate(nk) >= 0) a.status = ST_PRESENT;
                    else begin
                        keys[id] = nk;
                        a.ok = 1; a.status = ST_OK; a.found_id = 8'(id); a.found_key = nk;
                    end
                end
                CMD_FIND: begin
                    hit = locate(k);
                    if (hit < 0) a.status = ST_ABSENT;
                    else begin
                        a.ok = 1; a.status = ST_OK; a.found_id = 8'(hit); a.found_key = k;
                    end
                end
                CMD_INSERT: begin
                    first = -1; second = -1; hit = -1;
                    for (int i = 0; i <= top; i++) begin
                        if (used[i]) begin
                            if (keys[i] == k) begin hit = i; break; end
                        end else if (first < 0) first = i;
                        else if (second < 0) second = i;
                    end
                    if (hit >= 0) begin
                        a.status = ST_PRESENT; a.found_id = 8'(hit); a.found_key = k;
                    end else if (first < 0 && top >= DEPTH - 1) begin
                        a.status = ST_FULL;
                    end else begin
                        if (first < 0) begin
                            top++;
                            first = top;
                        end
                        keys[first] = k;
                        used[first] = 1;
                        hint = (second >= 0) ? second : top + 1;
                        count++;
                        a.ok = 1; a.status = ST_OK; a.found_id = 8'(first); a.found_key = k;
                    end
                end
                CMD_REMOVE: begin
                    hit = locate(k);
                    if (hit < 0) a.status = ST_ABSENT;
                    else begin
                        a.ok = 1; a.status = ST_OK; a.found_id = 8'(hit); a.found_key = k;
                        release_slot(hit);
                    end
                end
                CMD_UPDATE: begin
                    hit = locate(k);
                    if (hit < 0) a.status = ST_ABSENT;
                    else if (locate(nk) >= 0) a.status = ST_PRESENT;
                    else begin
                        keys[hit] = nk;
                        a.ok = 1; a.status = ST_OK; a.found_id = 8'(hit); a.found_key = nk;
                    end
                end
                CMD_TRUNCATE: begin
                    wipe();
                    a.ok = 1; a.status = ST_OK;
                end
                default: ;
            endcase
            a.entry_count = 9'(count);
            a.top_id = 9'(top);
            a.hint_id = 9'(hint);
            pending.push_back(a);
        endfunction

        // compare one result word with the oldest expectation
        task check_result(logic [103:0] data, logic [3:0] user);
            t_answer w;
            if (pending.size() == 0) begin
                report("unexpected word", data[63:0], 64'(0));
                return;
            end
            w = pending.pop_front();
            if (user[0] !== w.ok) report("ok", 64'(user[0]), 64'(w.ok));
            if (user[3:1] !== w.status) report("status", 64'(user[3:1]), 64'(w.status));
            if (data[7:0] !== w.found_id)
                report("found_id", 64'(data[7:0]), 64'(w.found_id));
            if (data[71:8] !== w.found_key) report("found_key", data[71:8], w.found_key);
            if (data[80:72] !== w.entry_count)
                report("entry_count", 64'(data[80:72]), 64'(w.entry_count));
            if (data[89:81] !== w.top_id)
                report("top_id", 64'(data[89:81]), 64'(w.top_id));
            if (data[98:90] !== w.hint_id)
                report("hint_id", 64'(data[98:90]), 64'(w.hint_id));
            if (data[103:99] !== '0) report("pad", 64'(data[103:99]), 64'(0));
        endtask
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_s_tvalid = 0;
    logic         o_s_tready;
    logic [143:0] i_s_tdata = '0;
    logic [3:0]   i_s_tuser = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 0;
    logic [103:0] o_m_tdata;
    logic [3:0]   o_m_tuser;

    dict_scoreboard board = new();
    logic [63:0] key_pool[16];
    bit          sending_done = 0;
    bit          hold_off = 0;
    int          quiet_cycles = 0;

    key_to_id_dictionary_table i_dut (.*);

    always #5 i_clk = ~i_clk;

    // send one command word, after an optional random gap
    task automatic send(input logic [3:0] cmd, input logic [8:0] id,
                        input logic [63:0] k, input logic [63:0] nk, input bit gap = 1);
        int idle;
        idle = gap ? $urandom_range(0, 5) : 0;
        if (idle > 0) begin
            i_s_tvalid <= 0;
            repeat (idle) @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tuser <= cmd;
        i_s_tdata <= {7'b0, nk, k, id};
        do @(posedge i_clk); while (!o_s_tready);
        board.note_command(cmd, id, k, nk);
    endtask

    function automatic logic [63:0] wide_random();
        return {$urandom, $urandom};
    endfunction

    // mostly pool keys so that hits and collisions occur
    function automatic logic [63:0] pick_key();
        return ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 15)] : wide_random();
    endfunction

    function automatic logic [8:0] pick_id();
        case ($urandom_range(0, 9))
            0: return 9'h1ff;
            1: return 9'($urandom);
            default: return 9'($urandom_range(0, (board.top < 0) ? 3 : board.top + 1));
        endcase
    endfunction

    // stimulus
    initial begin
        foreach (key_pool[i]) key_pool[i] = wide_random();
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: every command, empty table, extremes, failures
        send(CMD_GET, 9'h1ff, '0, '0);
        send(CMD_NEXT, 9'h1ff, '0, '0);
        send(CMD_FIND, 0, '1, '0);
        send(CMD_INSERT, 0, '0, '0);
        send(CMD_INSERT, 0, '1, '0);
        send(CMD_INSERT, 0, '1, '0);
        send(CMD_INSERT, 0, 64'h5555_aaaa_5555_aaaa, '0);
        send(CMD_GET, 1, '0, '0);
        send(CMD_GET, 9'hff, '0, '0);
        send(CMD_NEXT, 0, '0, '0);
        send(CMD_NEXT, 2, '0, '0);
        send(CMD_UNSET, 0, '0, '0);
        send(CMD_UNSET, 0, '0, '0);
        send(CMD_RESET, 1, '0, '1);
        send(CMD_RESET, 1, '0, 64'h1234);
        send(CMD_RESET, 0, '0, 64'h99);
        send(CMD_UPDATE, 9'h0, 64'h1234, '1);
        send(CMD_UPDATE, 0, 64'h1234, 64'haaaa_5555_aaaa_5555);
        send(CMD_UPDATE, 0, 64'h7, 64'h8);
        send(CMD_REMOVE, 0, 64'h5555_aaaa_5555_aaaa, '0);
        send(CMD_REMOVE, 0, 64'h5555_aaaa_5555_aaaa, '0);
        send(CMD_INSERT, 0, 64'h42, '0);
        send(4'd9, 0, '0, '0);
        send(4'd15, 9'h0ff, '1, '1);
        send(CMD_TRUNCATE, 0, '0, '0);
        // fill the table completely, then hit the full case
        for (int i = 0; i < DEPTH; i++) send(CMD_INSERT, 0, wide_random(), '0, 0);
        send(CMD_INSERT, 0, wide_random(), '0);
        send(CMD_GET, 9'h0ff, '0, '0);
        send(CMD_NEXT, 9'h0fe, '0, '0);
        send(CMD_UNSET, 9'h080, '0, '0);
        send(CMD_UNSET, 9'h010, '0, '0);
        send(CMD_INSERT, 0, wide_random(), '0);
        send(CMD_TRUNCATE, 0, '0, '0);
        // random commands on a small key pool
        for (int n = 0; n < 460; n++) begin
            logic [3:0] c;
            c = 4'($urandom_range(0, 99) < 2 ? $urandom_range(9, 15) : $urandom_range(0, 7));
            if ($urandom_range(0, 199) == 0) c = CMD_TRUNCATE;
            if (c == CMD_INSERT || $urandom_range(0, 3) == 0 && board.count < 20) c = CMD_INSERT;
            if (n % 100 == 99) key_pool[$urandom_range(2, 15)] = wide_random();
            send(c, pick_id(), pick_key(), pick_key(), n % 200 > 40);
        end
        i_s_tvalid <= 0;
        sending_done = 1;
    end

    // receiver with random stalls and one long hold-off
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off) i_m_tready <= 0;
            else i_m_tready <= ($urandom_range(0, 5) == 0) ? 0 : 1;
        end
    end

    initial begin
        repeat (400) @(posedge i_clk);
        hold_off = 1;
        repeat (1500) @(posedge i_clk);
        hold_off = 0;
    end

    // result checking and watchdog
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready) board.check_result(o_m_tdata, o_m_tuser);
        if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= 5000);
        $display("timeout");
        $display("[FAIL] regression broken");
        $finish;
    end

    // end of run
    initial begin
        do @(posedge i_clk); while (!(sending_done && board.pending.size() == 0));
        repeat (600) @(posedge i_clk);
        if (board.pending.size() != 0) n_errors++;
        if (n_errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule
